@@ design/krp_pkg.sv @@
`timescale 1ns / 1ps
package krp_pkg;

   // Hash seed and MurmurHash3 mixing constants.
   localparam logic [31:0] KRP_SEED = 32'h9747b28c;
   localparam logic [31:0] KRP_C1   = 32'hcc9e2d51;
   localparam logic [31:0] KRP_C2   = 32'h1b873593;
   localparam logic [31:0] KRP_C3   = 32'he6546b64;
   localparam logic [31:0] KRP_F1   = 32'h85ebca6b;
   localparam logic [31:0] KRP_F2   = 32'hc2b2ae35;

   // Partition count limits. The count field is 11 bits and the index is 10 bits.
   localparam int KRP_MAX_PARTITIONS = 1024;
   localparam int KRP_OUT_LIMIT      = 1024;
   localparam int KRP_COUNT_LIMIT    = (KRP_MAX_PARTITIONS < KRP_OUT_LIMIT) ?
                                       KRP_MAX_PARTITIONS : KRP_OUT_LIMIT;
   localparam int KRP_COUNT_W        = 11;
   localparam int KRP_PART_W         = 10;

   // Queue between the front and back parts.
   localparam int KRP_QUEUE_DEPTH = 2;
   localparam int KRP_QPTR_W      = (KRP_QUEUE_DEPTH > 1) ? $clog2(KRP_QUEUE_DEPTH) : 1;
   localparam int KRP_QCNT_W      = $clog2(KRP_QUEUE_DEPTH + 1);

   // Action codes of the input channel.
   localparam logic KRP_ACT_KEY_BYTE = 1'b0;
   localparam logic KRP_ACT_KEYLESS  = 1'b1;

   // One queued message: either a completed key or a keyless publish.
   typedef struct packed {
      logic        keyless;
      logic [31:0] hash;
      logic [23:0] word;
      logic [31:0] length;
   } krp_entry_type;

   function automatic logic [31:0] krp_rotl13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

   function automatic logic [31:0] krp_rotl15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

endpackage

@@ design/krp_front.sv @@
`timescale 1ns / 1ps
module krp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [7:0]             req_key_byte,
   input  logic                   req_last,
   input  logic                   q_full,
   output logic                   q_push,
   output krp_pkg::krp_entry_type q_push_data
);
   import krp_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL1 = 4'b0010,
      F_MUL2 = 4'b0100,
      F_MIX  = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [23:0] word_ff, word_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] mul_ff, mul_in;
   logic        last_ff, last_in;

   logic        accept;
   logic [23:0] word_merged;
   logic [31:0] hash_mixed;
   logic [31:0] mul_a;
   logic [31:0] mul_c;
   logic [31:0] mul_p;

   assign req_ready = (state_ff == F_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;

   // Place the incoming byte at its little-endian position in the pending word.
   always_comb begin
      case (len_ff[1:0])
         2'd0:    word_merged = word_ff | {16'b0, req_key_byte};
         2'd1:    word_merged = word_ff | {8'b0, req_key_byte, 8'b0};
         2'd2:    word_merged = word_ff | {req_key_byte, 16'b0};
         default: word_merged = word_ff;
      endcase
   end

   // One shared multiplier for both scramble products of a full word.
   assign mul_a = (state_ff == F_MUL2) ? krp_rotl15(mul_ff) : mul_ff;
   assign mul_c = (state_ff == F_MUL2) ? KRP_C2 : KRP_C1;
   assign mul_p = mul_a * mul_c;

   // Block mix: rotate, then multiply by five and add.
   always_comb begin
      logic [31:0] r;
      r          = krp_rotl13(hash_ff ^ mul_ff);
      hash_mixed = {r[29:0], 2'b00} + r + KRP_C3;
   end

   // Byte absorption and message hand-off to the queue.
   always_comb begin
      state_in    = state_ff;
      hash_in     = hash_ff;
      word_in     = word_ff;
      len_in      = len_ff;
      mul_in      = mul_ff;
      last_in     = last_ff;
      q_push      = 1'b0;
      q_push_data = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_action == KRP_ACT_KEYLESS) begin
                  q_push              = 1'b1;
                  q_push_data.keyless = 1'b1;
               end else if (len_ff[1:0] == 2'd3) begin
                  mul_in   = {req_key_byte, word_ff};
                  last_in  = req_last;
                  len_in   = len_ff + 32'd1;
                  state_in = F_MUL1;
               end else if (req_last) begin
                  q_push             = 1'b1;
                  q_push_data.hash   = hash_ff;
                  q_push_data.word   = word_merged;
                  q_push_data.length = len_ff + 32'd1;
                  hash_in            = KRP_SEED;
                  word_in            = '0;
                  len_in             = '0;
               end else begin
                  word_in = word_merged;
                  len_in  = len_ff + 32'd1;
               end
            end
         end
         F_MUL1: begin
            mul_in   = mul_p;
            state_in = F_MUL2;
         end
         F_MUL2: begin
            mul_in   = mul_p;
            state_in = F_MIX;
         end
         F_MIX: begin
            word_in  = '0;
            state_in = F_IDLE;
            if (last_ff) begin
               q_push             = 1'b1;
               q_push_data.hash   = hash_mixed;
               q_push_data.length = len_ff;
               hash_in            = KRP_SEED;
               len_in             = '0;
            end else begin
               hash_in = hash_mixed;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Key state resets to the seed; the multiplier register carries payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         hash_ff  <= KRP_SEED;
         word_ff  <= '0;
         len_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         word_ff  <= word_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
   end

endmodule

@@ design/krp_queue.sv @@
`timescale 1ns / 1ps
module krp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  krp_pkg::krp_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output krp_pkg::krp_entry_type pop_data
);
   import krp_pkg::*;

   krp_entry_type           mem_ff [KRP_QUEUE_DEPTH];
   logic [KRP_QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [KRP_QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [KRP_QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == KRP_QCNT_W'(KRP_QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates; callers never push when full or pop when empty.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == KRP_QPTR_W'(KRP_QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + KRP_QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == KRP_QPTR_W'(KRP_QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + KRP_QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + KRP_QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - KRP_QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/krp_back.sv @@
`timescale 1ns / 1ps
module krp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [krp_pkg::KRP_COUNT_W-1:0] count,
   input  logic                          q_not_empty,
   input  krp_pkg::krp_entry_type        q_pop_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [krp_pkg::KRP_PART_W-1:0] rsp_partition,
   output logic [31:0]                   rsp_hash_value,
   output logic                          rsp_by_round_robin
);
   import krp_pkg::*;

   typedef enum logic [7:0] {
      B_IDLE  = 8'b0000_0001,
      B_TAIL1 = 8'b0000_0010,
      B_TAIL2 = 8'b0000_0100,
      B_FMIX1 = 8'b0000_1000,
      B_FMIX2 = 8'b0001_0000,
      B_FMIX3 = 8'b0010_0000,
      B_DIV   = 8'b0100_0000,
      B_DONE  = 8'b1000_0000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic                    keyless_ff, keyless_in;
   logic [31:0]             h_ff, h_in;
   logic [31:0]             len_ff, len_in;
   logic [31:0]             mul_ff, mul_in;
   logic [31:0]             div_ff, div_in;
   logic [KRP_COUNT_W-1:0]  rem_ff, rem_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [KRP_PART_W-1:0]   rr_ff, rr_in;

   logic                    out_valid_ff, out_valid_in;
   logic [KRP_PART_W-1:0]   out_part_ff;
   logic [31:0]             out_hash_ff;
   logic                    out_rr_ff;

   logic                    load;
   logic [31:0]             mul_a;
   logic [31:0]             mul_c;
   logic [31:0]             mul_p;
   logic [31:0]             fmix1_val;
   logic [KRP_COUNT_W:0]    div_shift;
   logic [KRP_COUNT_W:0]    rr_next;

   assign rsp_valid          = out_valid_ff;
   assign rsp_partition      = out_part_ff;
   assign rsp_hash_value     = out_hash_ff;
   assign rsp_by_round_robin = out_rr_ff;

   assign q_pop = (state_ff == B_IDLE) && q_not_empty;
   assign load  = (state_ff == B_DONE) && (!out_valid_ff || rsp_ready);

   // Tail word folded in only when the length is not a multiple of four.
   assign fmix1_val = h_ff ^ ((len_ff[1:0] != 2'd0) ? mul_ff : 32'd0) ^ len_ff;

   // Shared multiplier for tail scramble and finalizer products.
   always_comb begin
      mul_a = mul_ff;
      mul_c = KRP_C1;
      case (state_ff)
         B_TAIL2: begin
            mul_a = krp_rotl15(mul_ff);
            mul_c = KRP_C2;
         end
         B_FMIX1: begin
            mul_a = fmix1_val ^ {16'b0, fmix1_val[31:16]};
            mul_c = KRP_F1;
         end
         B_FMIX2: begin
            mul_a = mul_ff ^ {13'b0, mul_ff[31:13]};
            mul_c = KRP_F2;
         end
         default: begin
            mul_a = mul_ff;
            mul_c = KRP_C1;
         end
      endcase
   end
   assign mul_p = mul_a * mul_c;

   // One restoring division step per cycle.
   assign div_shift = {rem_ff, div_ff[31]};
   assign rr_next   = {2'b00, rem_ff[KRP_PART_W-1:0]} + {{KRP_COUNT_W{1'b0}}, 1'b1};

   // Finalize keyed hashes, reduce modulo the count, load the output register.
   always_comb begin
      state_in   = state_ff;
      keyless_in = keyless_ff;
      h_in       = h_ff;
      len_in     = len_ff;
      mul_in     = mul_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      rr_in      = rr_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               keyless_in = q_pop_data.keyless;
               h_in       = q_pop_data.hash;
               len_in     = q_pop_data.length;
               mul_in     = {8'b0, q_pop_data.word};
               rem_in     = '0;
               cnt_in     = '0;
               if (q_pop_data.keyless) begin
                  div_in   = {{(32 - KRP_PART_W){1'b0}}, rr_ff};
                  state_in = B_DIV;
               end else begin
                  state_in = B_TAIL1;
               end
            end
         end
         B_TAIL1: begin
            mul_in   = mul_p;
            state_in = B_TAIL2;
         end
         B_TAIL2: begin
            mul_in   = mul_p;
            state_in = B_FMIX1;
         end
         B_FMIX1: begin
            mul_in   = mul_p;
            state_in = B_FMIX2;
         end
         B_FMIX2: begin
            mul_in   = mul_p;
            state_in = B_FMIX3;
         end
         B_FMIX3: begin
            h_in     = mul_ff ^ {16'b0, mul_ff[31:16]};
            div_in   = mul_ff ^ {16'b0, mul_ff[31:16]};
            state_in = B_DIV;
         end
         B_DIV: begin
            if (div_shift >= {1'b0, count}) begin
               rem_in = KRP_COUNT_W'(div_shift - {1'b0, count});
            end else begin
               rem_in = div_shift[KRP_COUNT_W-1:0];
            end
            div_in = {div_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load) begin
               state_in = B_IDLE;
               if (keyless_ff) begin
                  rr_in = (rr_next >= {1'b0, count}) ? '0 : rr_next[KRP_PART_W-1:0];
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Output register: holds a result while the next message is worked on.
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rr_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_ff        <= rr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath and result payload registers.
   always_ff @(posedge clock) begin
      keyless_ff <= keyless_in;
      h_ff       <= h_in;
      len_ff     <= len_in;
      mul_ff     <= mul_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      if (load) begin
         out_part_ff <= rem_ff[KRP_PART_W-1:0];
         out_hash_ff <= keyless_ff ? 32'd0 : h_ff;
         out_rr_ff   <= keyless_ff;
      end
   end

endmodule

@@ design/key_partition_router_core.sv @@
`timescale 1ns / 1ps
// A key byte that completes a 32-bit word also runs the front's MUL1, MUL2 and MIX states
// (scramble and mix) with req_ready low. A finished key goes through the queue and the back
// part's TAIL1, TAIL2, FMIX1, FMIX2, FMIX3 and DIV states to the output register; keyless
// skips to DIV. The back part's bit-serial modulo sets the message rate; it takes the next
// message once its result is loaded, and key bytes stream on while the queue has room.
// Reset is synchronous, active high: seed hash, zero length and round robin, count of one.
module key_partition_router_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [7:0]                      req_key_byte,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [krp_pkg::KRP_PART_W-1:0]  rsp_partition,
   output logic [31:0]                     rsp_hash_value,
   output logic                            rsp_by_round_robin,
   input  logic                            csr_wr_en,
   input  logic [krp_pkg::KRP_COUNT_W-1:0] csr_wr_data
);
   import krp_pkg::*;

   logic [KRP_COUNT_W-1:0] num_part_ff, num_part_in;
   logic [KRP_COUNT_W-1:0] count_eff;
   logic                   q_full;
   logic                   q_push;
   krp_entry_type          q_push_data;
   logic                   q_pop;
   logic                   q_not_empty;
   krp_entry_type          q_pop_data;

   // Partition count register.
   assign num_part_in = csr_wr_en ? csr_wr_data : num_part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_part_ff <= KRP_COUNT_W'(1);
      end else begin
         num_part_ff <= num_part_in;
      end
   end

   // A zero count acts as one; a count above the limit saturates.
   always_comb begin
      if (num_part_ff == '0) begin
         count_eff = KRP_COUNT_W'(1);
      end else if (num_part_ff > KRP_COUNT_W'(KRP_COUNT_LIMIT)) begin
         count_eff = KRP_COUNT_W'(KRP_COUNT_LIMIT);
      end else begin
         count_eff = num_part_ff;
      end
   end

   krp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_key_byte (req_key_byte),
      .req_last     (req_last),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   krp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   krp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .count              (count_eff),
      .q_not_empty        (q_not_empty),
      .q_pop_data         (q_pop_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_partition      (rsp_partition),
      .rsp_hash_value     (rsp_hash_value),
      .rsp_by_round_robin (rsp_by_round_robin)
   );

endmodule
